[rtl/lru_recency_queue_macros.svh]
// assertion macros for the recency queue
`ifndef LRU_RECENCY_QUEUE_MACROS_SVH
`define LRU_RECENCY_QUEUE_MACROS_SVH

// checked outside reset
`define LRQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define LRQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/lrq_pkg.sv]
package lrq_pkg;

  localparam int DEPTH  = 16;
  localparam int PAGE_W = 48;
  localparam int OCC_W  = 5;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);

  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [IDX_W-1:0]  index_t;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_TOUCH  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    action_t action;
    page_t   page_address;
  } request_t;

  typedef struct packed {
    status_t          status;
    page_t            removed_page;
    logic [OCC_W-1:0] occupancy;
    logic             is_full;
    logic             is_empty;
  } result_t;

  typedef struct packed {
    logic   compare;
    logic   append;
    logic   remove;
    logic   touch;
    count_t count;
    page_t  page;
  } cell_ctrl_t;

  // inclusive prefix or from the oldest slot upward
  function automatic logic [DEPTH-1:0] prefix_or(input logic [DEPTH-1:0] v);
    logic [DEPTH-1:0] r;
    r = v;
    for (int s = 1; s < DEPTH; s = s * 2) begin
      r = r | (r << s);
    end
    return r;
  endfunction

endpackage

[rtl/lru_recency_queue.sv]
// Page recency queue, oldest entry in slot 0. An item is taken when start is high and busy
// is low; busy then stays high through S_CMP and S_APPLY: in S_CMP every cell compares its
// entry with the page and registers a match flag, in S_APPLY the cells shift toward the
// oldest end on a remove or touch, load the appended or touched page and the result word is
// registered. done is high for exactly one cycle right after that, with the result word,
// and the receiver cannot hold it off. A new item can be taken in that same cycle, but none
// while busy is high. The search spans the whole row of cells at once; the oldest match is
// picked by a prefix tree of log2(depth) levels over the registered match flags.
`include "lru_recency_queue_macros.svh"

module lru_recency_queue
  import lrq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     done,
  output result_t  result
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CMP   = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t           state;
  request_t         req;
  count_t           count;
  count_t           count_next;
  page_t            entries [DEPTH];
  logic [DEPTH-1:0] match_vec;
  logic [DEPTH-1:0] below;
  cell_ctrl_t       ctrl;
  logic             found;
  logic             full;
  logic             empty;
  logic             do_append;
  logic             do_remove;
  logic             do_touch;
  status_t          status;
  page_t            removed;

  assign busy  = state != S_IDLE;
  assign full  = count == CNT_W'(DEPTH);
  assign empty = count == '0;
  assign below = prefix_or(match_vec);
  assign found = |match_vec;

  always_comb begin
    do_append  = 1'b0;
    do_remove  = 1'b0;
    do_touch   = 1'b0;
    status     = ST_OK;
    removed    = '0;
    count_next = count;
    case (req.action)
      ACT_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          do_append  = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      ACT_REMOVE: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          do_remove  = 1'b1;
          removed    = entries[0];
          count_next = count - CNT_W'(1);
        end
      end
      ACT_TOUCH: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (!found) begin
          status = ST_NOT_FOUND;
        end else begin
          do_touch = 1'b1;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  always_comb begin
    ctrl.compare = state == S_CMP;
    ctrl.append  = (state == S_APPLY) && do_append;
    ctrl.remove  = (state == S_APPLY) && do_remove;
    ctrl.touch   = (state == S_APPLY) && do_touch;
    ctrl.count   = count;
    ctrl.page    = req.page_address;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    page_t nbr;
    if (i == DEPTH - 1) begin : g_last
      assign nbr = entries[i];
    end else begin : g_mid
      assign nbr = entries[i+1];
    end
    lrq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .index      (IDX_W'(i)),
      .next_entry (nbr),
      .hit_below  (below[i]),
      .entry      (entries[i]),
      .match      (match_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req <= request;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_APPLY) begin
      result.status       <= status;
      result.removed_page <= removed;
      result.occupancy    <= OCC_W'(count_next);
      result.is_full      <= count_next == CNT_W'(DEPTH);
      result.is_empty     <= count_next == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          count <= count_next;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `LRQ_ASSERT(a_done_follows_apply, done |-> $past(state == S_APPLY), "done without apply")
  `LRQ_ASSERT(a_done_not_busy, done |-> !busy, "done while busy")
  `LRQ_ASSERT(a_count_bounded, count <= CNT_W'(DEPTH), "count beyond depth")
  `LRQ_ASSERT(a_count_only_in_apply, (!$past(rst) && $past(state != S_APPLY)) |-> $stable(count), "count moved outside apply")
  `LRQ_ASSERT_ALWAYS(a_reset_idle, rst |=> (!busy && !done), "not idle after reset")

endmodule

[rtl/lrq_cell.sv]
module lrq_cell
  import lrq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  index_t     index,
  input  page_t      next_entry,
  input  logic       hit_below,
  output page_t      entry,
  output logic       match
);

  count_t idx_ext;
  count_t idx_inc;
  logic   valid;
  logic   newest;

  assign idx_ext = CNT_W'(index);
  assign idx_inc = idx_ext + CNT_W'(1);
  assign valid   = idx_ext < ctrl.count;
  assign newest  = idx_inc == ctrl.count;

  always_ff @(posedge clk) begin
    if (ctrl.compare) begin
      match <= valid && (entry == ctrl.page);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.append && (idx_ext == ctrl.count)) begin
      entry <= ctrl.page;
    end else if (ctrl.remove) begin
      entry <= next_entry;
    end else if (ctrl.touch && hit_below && valid) begin
      entry <= newest ? ctrl.page : next_entry;
    end
  end

endmodule
